FILE: hdl/b64e_pkg.sv
// Shared types, constants and the character map of the Base64 encoder.
`default_nettype none
package b64e_pkg;

	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef logic [1:0] fill_t;

	// One complete or closed group as handed from front to back.
	typedef struct packed {
		logic [3:0][5:0] sext;
		fill_t           fill;  // bytes held before the closing byte, 0..2
		logic            last;
	} group_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h47 + w;
		end else if (v < 6'd62) begin
			return w - 8'd4;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage
`default_nettype wire

FILE: hdl/b64e_msg_if.sv
// Byte channel: one message byte and its last-byte flag per beat.
`default_nettype none
interface b64e_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, data_byte, final_byte, input ready);
	modport sink(input valid, data_byte, final_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/b64e_char_if.sv
// Character channel: one encoded ASCII character and its last flag per beat.
`default_nettype none
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       final_char;

	modport source(output valid, char_code, final_char, input ready);
	modport sink(input valid, char_code, final_char, output ready);
endinterface
`default_nettype wire

FILE: hdl/base64_stream_encoder.sv
// Base64 encoder (standard alphabet, '=' padding) over byte and character streams.
// Bytes enter one per cycle while the two-entry group queue has room; the byte
// that completes a group of three, or any byte flagged final, closes the group
// and the back end then emits its four characters, one character per cycle
// while the output is taken, through a registered output. Sustained throughput
// is therefore set by the output: four characters for each three bytes. A closing
// byte is written into the group queue, and its first character then into the
// output register, which drives it on the output. A final byte
// in a group of one or two bytes gives two or three characters and '=' pads;
// the fourth character of a closing group carries final_char when the group
// held the final byte. The group state clears after each final byte.
`default_nettype none
module base64_stream_encoder
	import b64e_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	b64e_msg_if.sink    msg,
	b64e_char_if.source enc
);

	group_t push_data;
	group_t head_data;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	b64e_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.q_full (full),
		.q_push (push),
		.q_data (push_data)
	);

	b64e_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.full    (full),
		.pop     (pop),
		.rd_data (head_data),
		.empty   (empty)
	);

	b64e_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (head_data),
		.q_empty (empty),
		.q_pop   (pop),
		.enc     (enc)
	);

endmodule
`default_nettype wire

FILE: hdl/b64e_queue.sv
// Short group queue between the byte front end and the character back end.
`default_nettype none
module b64e_queue
	import b64e_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  group_t      wr_data,
	output logic        full,
	input  wire logic   pop,
	output group_t      rd_data,
	output logic        empty
);

	group_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	function automatic logic [QAW-1:0] next_ptr(input logic [QAW-1:0] p);
		return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
	endfunction

	assign full    = (count_q == QCW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("group queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("group queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("group queue count out of range");

endmodule
`default_nettype wire

FILE: hdl/b64e_front.sv
// Front end: collects bytes into groups and splits closed groups into sextets.
`default_nettype none
module b64e_front
	import b64e_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	b64e_msg_if.sink    msg,
	input  wire logic   q_full,
	output logic        q_push,
	output group_t      q_data
);

	fill_t       fill_q;
	logic [15:0] pending_q;
	logic        accept;
	logic        closes;
	logic [7:0]  b0, b1, b2;

	assign msg.ready = !q_full;
	assign accept    = msg.valid && msg.ready;
	assign closes    = (fill_q == 2'd2) || msg.final_byte;
	assign q_push    = accept && closes;

	always_comb begin
		b0 = pending_q[15:8];
		b1 = pending_q[7:0];
		b2 = 8'h00;
		case (fill_q)
			2'd0: begin
				b0 = msg.data_byte;
				b1 = 8'h00;
			end
			2'd1: begin
				b1 = msg.data_byte;
			end
			default: begin
				b2 = msg.data_byte;
			end
		endcase
		q_data.sext[0] = b0[7:2];
		q_data.sext[1] = {b0[1:0], b1[7:4]};
		q_data.sext[2] = {b1[3:0], b2[7:6]};
		q_data.sext[3] = b2[5:0];
		q_data.fill    = fill_q;
		q_data.last    = msg.final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pending_q <= '0;
		end else if (accept) begin
			if (closes) begin
				fill_q    <= '0;
				pending_q <= '0;
			end else begin
				fill_q <= fill_q + 2'd1;
				if (fill_q == 2'd0) begin
					pending_q <= {msg.data_byte, 8'h00};
				end else begin
					pending_q <= {pending_q[15:8], msg.data_byte};
				end
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("group fill reached three");
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && msg.final_byte |=> fill_q == 2'd0 && pending_q == '0)
		else $error("group state not cleared after last byte");
	a_third_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fill_q == 2'd2 |-> q_push)
		else $error("third byte did not close its group");

endmodule
`default_nettype wire

FILE: hdl/b64e_back.sv
// Back end: emits the four characters of each queued group through an output register.
`default_nettype none
module b64e_back
	import b64e_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  group_t      q_data,
	input  wire logic   q_empty,
	output logic        q_pop,
	b64e_char_if.source enc
);

	logic [1:0] k_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic [7:0] char_d;

	assign load  = !q_empty && (!valid_q || enc.ready);
	assign q_pop = load && (k_q == 2'd3);

	// char k carries data while k <= fill + 1, '=' after that
	always_comb begin
		if ({1'b0, k_q} <= {1'b0, q_data.fill} + 3'd1) begin
			char_d = b64_char(q_data.sext[k_q]);
		end else begin
			char_d = PAD_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q     <= k_q + 2'd1;
				valid_q <= 1'b1;
			end else if (enc.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_d;
			last_q <= q_data.last && (k_q == 2'd3);
		end
	end

	assign enc.valid      = valid_q;
	assign enc.char_code  = char_q;
	assign enc.final_char = last_q;

	a_pop_on_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> k_q == 2'd0)
		else $error("character index not wrapped after group");
	a_hold_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> k_q == $past(k_q))
		else $error("character index moved without a load");
	a_last_is_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		load && q_data.last && k_q == 2'd3 |=> valid_q && last_q)
		else $error("last character not flagged");

endmodule
`default_nettype wire
